FILE: rtl/dbda_pkg.sv
// Shared widths, codes and register addresses for the duty balance distance advisor.
// Depends on nothing; the advice interface and the advisor take names from here by scope.
`default_nettype none

package dbda_pkg;

  localparam int TIME_BITS  = 24;
  localparam int COUNT_BITS = 10;
  localparam int TOL_BITS   = 16;
  localparam int DIFF_BITS  = TIME_BITS + 1;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Register reset values
  localparam logic [COUNT_BITS-1:0] TPR_RESET     = COUNT_BITS'(100);
  localparam logic [TOL_BITS-1:0]   TOL_RESET     = TOL_BITS'(1000);
  localparam logic [TIME_BITS-1:0]  TIMEOUT_RESET = TIME_BITS'(1000000);

  // Register word indexes (byte address / 4)
  localparam logic [1:0] REG_TPR     = 2'd0;
  localparam logic [1:0] REG_TOL     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK          = 3'd0;
  localparam logic [2:0] VERDICT_MOVE_AWAY   = 3'd1;
  localparam logic [2:0] VERDICT_MOVE_CLOSER = 3'd2;
  localparam logic [2:0] VERDICT_NO_PHASES   = 3'd3;
  localparam logic [2:0] VERDICT_SEV_CLOSE   = 3'd4;
  localparam logic [2:0] VERDICT_SEV_FAR     = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/dbda_sample_if.sv
// Input channel: one sensor level beat per microsecond tick.
// Depends on no other file.
`default_nettype none

interface dbda_sample_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink   (input valid, input sensor_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/dbda_advice_if.sv
// Output channel: one report or timeout verdict beat.
// Depends on dbda_pkg for field widths.
`default_nettype none

interface dbda_advice_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic [2:0]                          verdict;
  logic [dbda_pkg::TIME_BITS-1:0]      avg_high_ticks;
  logic [dbda_pkg::TIME_BITS-1:0]      avg_low_ticks;
  logic signed [dbda_pkg::DIFF_BITS-1:0] avg_difference;

  modport source (output valid, output result_kind, output verdict, output avg_high_ticks,
                  output avg_low_ticks, output avg_difference, input ready);
  modport sink   (input valid, input result_kind, input verdict, input avg_high_ticks,
                  input avg_low_ticks, input avg_difference, output ready);
endinterface

`default_nettype wire

FILE: rtl/duty_balance_distance_advisor.sv
// Duty balance distance advisor: sequencer, phase timers, APB registers and
// a shared restoring divider. Depends on dbda_pkg, dbda_sample_if, dbda_advice_if.
//
// Usage: feed one sensor_level beat per microsecond tick on the sample channel.
// Each tick times the current high/low phase; after transitions_per_report timed
// transitions an averaged report leaves on the advice channel, and when the window
// reaches timeout_ticks a timeout verdict leaves instead.
// Flow: a tick that gives no result or a timeout verdict is handled in the idle state;
// the timeout verdict is visible the cycle after the tick is accepted. A tick that
// closes a report starts the one shared divider, which runs one quotient bit per
// cycle, first for the high sum, then for the low sum; the finish state then forms
// the difference and advice. The sample channel is not ready while the divider runs.
// The result sits in an output register; the sample channel is ready only while that
// register is empty or being taken, so a stalled receiver holds off new ticks.
// Reset (rst, synchronous, active high) restores register defaults (100, 1000,
// 1000000), clears all timers and sums, forgets the previous level and empties the
// output register. Registers: byte 0 transitions_per_report, 4 tolerance_ticks,
// 8 timeout_ticks; pready is always high. Write registers only while idle.
`default_nettype none

module duty_balance_distance_advisor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  dbda_sample_if.sink                          sample,
  dbda_advice_if.source                        advice,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dbda_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [dbda_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [dbda_pkg::DATA_BITS-1:0]  prdata,
  output logic                                 pready
);

  localparam int TB  = dbda_pkg::TIME_BITS;
  localparam int CB  = dbda_pkg::COUNT_BITS;
  localparam int DB  = dbda_pkg::DIFF_BITS;
  localparam int CNT_W = $clog2(TB);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TB - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV_HI = 4'b0010,
    S_DIV_LO = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  // Configuration registers
  logic [CB-1:0]                 tpr;
  logic [dbda_pkg::TOL_BITS-1:0] tol;
  logic [TB-1:0]                 timeout;

  // Tick state
  state_t        state;
  logic          prev_valid;
  logic          prev_level;
  logic          edge_seen;
  logic [TB-1:0] ticks_since_edge;
  logic          window_started;
  logic [TB-1:0] window_ticks;
  logic [TB-1:0] last_high;
  logic [TB-1:0] last_low;
  logic [TB-1:0] high_sum;
  logic [TB-1:0] low_sum;
  logic [CB-1:0] trans_count;

  // Divider
  logic [CB-1:0]    div_rem;
  logic [TB-1:0]    div_quo;
  logic [CNT_W-1:0] div_cnt;
  logic [TB-1:0]    avg_high;

  // Tick next values
  logic          accept;
  logic [TB-1:0] tse_inc;
  logic [TB-1:0] wt_next;
  logic [TB-1:0] hs_base, ls_base;
  logic [CB-1:0] cnt_base;
  logic          timeout_hit;
  logic          level_change;
  logic [TB-1:0] lh_next, ll_next;
  logic [TB-1:0] hs_next, ls_next;
  logic [CB-1:0] cnt_next;
  logic [CB-1:0] need;
  logic          report_hit;
  logic [2:0]    timeout_verdict;
  logic [TB:0]   hs_wide, ls_wide;

  // Divider step
  logic [CB:0]   div_shift;
  logic [CB+1:0] div_trial;
  logic [CB-1:0] div_rem_next;
  logic [TB-1:0] div_quo_next;

  // Finish
  logic [DB-1:0] diff;
  logic [DB-1:0] mag;
  logic [2:0]    report_verdict;

  logic apb_write;
  logic out_load;

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      dbda_pkg::REG_TPR:     prdata = dbda_pkg::DATA_BITS'(tpr);
      dbda_pkg::REG_TOL:     prdata = dbda_pkg::DATA_BITS'(tol);
      dbda_pkg::REG_TIMEOUT: prdata = dbda_pkg::DATA_BITS'(timeout);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpr     <= dbda_pkg::TPR_RESET;
      tol     <= dbda_pkg::TOL_RESET;
      timeout <= dbda_pkg::TIMEOUT_RESET;
    end else if (apb_write) begin
      case (paddr[3:2])
        dbda_pkg::REG_TPR:     tpr     <= pwdata[CB-1:0];
        dbda_pkg::REG_TOL:     tol     <= pwdata[dbda_pkg::TOL_BITS-1:0];
        dbda_pkg::REG_TIMEOUT: timeout <= pwdata[TB-1:0];
        default: ;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE) && (!advice.valid || advice.ready);
  assign accept       = sample.valid && sample.ready;
  assign out_load     = (state == S_FINISH) || (accept && timeout_hit);

  always_comb begin
    tse_inc  = (ticks_since_edge == dbda_pkg::TIME_MAX) ? ticks_since_edge
                                                       : ticks_since_edge + 1'b1;
    if (!window_started) begin
      wt_next  = '0;
      hs_base  = '0;
      ls_base  = '0;
      cnt_base = '0;
    end else begin
      wt_next  = (window_ticks == dbda_pkg::TIME_MAX) ? window_ticks : window_ticks + 1'b1;
      hs_base  = high_sum;
      ls_base  = low_sum;
      cnt_base = trans_count;
    end
    timeout_hit  = (wt_next >= timeout);
    level_change = !prev_valid || (sample.sensor_level != prev_level);

    if (last_high == '0 && last_low == '0) timeout_verdict = dbda_pkg::VERDICT_NO_PHASES;
    else if (last_high > last_low)         timeout_verdict = dbda_pkg::VERDICT_SEV_CLOSE;
    else                                   timeout_verdict = dbda_pkg::VERDICT_SEV_FAR;

    // Time the phase that just ended under its own level
    lh_next  = prev_level ? tse_inc : '0;
    ll_next  = prev_level ? '0 : tse_inc;
    hs_wide  = {1'b0, hs_base} + {1'b0, lh_next};
    ls_wide  = {1'b0, ls_base} + {1'b0, ll_next};
    hs_next  = hs_wide[TB] ? dbda_pkg::TIME_MAX : hs_wide[TB-1:0];
    ls_next  = ls_wide[TB] ? dbda_pkg::TIME_MAX : ls_wide[TB-1:0];
    cnt_next = cnt_base + 1'b1;
    need     = (tpr == '0) ? CB'(1) : tpr;
    report_hit = edge_seen && (cnt_next >= need) && (cnt_next != '0);
  end

  always_comb begin
    div_shift    = {div_rem, div_quo[TB-1]};
    div_trial    = {1'b0, div_shift} - {2'b00, trans_count};
    if (!div_trial[CB+1]) begin
      div_rem_next = div_trial[CB-1:0];
      div_quo_next = {div_quo[TB-2:0], 1'b1};
    end else begin
      div_rem_next = div_shift[CB-1:0];
      div_quo_next = {div_quo[TB-2:0], 1'b0};
    end
  end

  always_comb begin
    diff = {1'b0, avg_high} - {1'b0, div_quo};
    mag  = diff[DB-1] ? (~diff + 1'b1) : diff;
    if (mag <= DB'(tol))  report_verdict = dbda_pkg::VERDICT_OK;
    else if (diff[DB-1])  report_verdict = dbda_pkg::VERDICT_MOVE_AWAY;
    else                  report_verdict = dbda_pkg::VERDICT_MOVE_CLOSER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      prev_valid       <= 1'b0;
      prev_level       <= 1'b0;
      edge_seen        <= 1'b0;
      ticks_since_edge <= '0;
      window_started   <= 1'b0;
      window_ticks     <= '0;
      last_high        <= '0;
      last_low         <= '0;
      high_sum         <= '0;
      low_sum          <= '0;
      trans_count      <= '0;
      advice.valid     <= 1'b0;
    end else begin
      // Drop the taken beat unless a new one loads at this edge
      if (advice.valid && advice.ready && !out_load) begin
        advice.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            window_ticks <= wt_next;
            if (timeout_hit) begin
              ticks_since_edge      <= tse_inc;
              high_sum              <= hs_base;
              low_sum               <= ls_base;
              trans_count           <= cnt_base;
              window_started        <= 1'b0;
              edge_seen             <= 1'b0;
              last_high             <= '0;
              last_low              <= '0;
              advice.valid          <= 1'b1;
              advice.result_kind    <= dbda_pkg::KIND_TIMEOUT;
              advice.verdict        <= timeout_verdict;
              advice.avg_high_ticks <= '0;
              advice.avg_low_ticks  <= '0;
              advice.avg_difference <= '0;
            end else begin
              window_started <= 1'b1;
              if (!level_change) begin
                ticks_since_edge <= tse_inc;
                high_sum         <= hs_base;
                low_sum          <= ls_base;
                trans_count      <= cnt_base;
              end else begin
                ticks_since_edge <= '0;
                edge_seen        <= 1'b1;
                prev_valid       <= 1'b1;
                prev_level       <= sample.sensor_level;
                if (edge_seen) begin
                  last_high   <= lh_next;
                  last_low    <= ll_next;
                  high_sum    <= hs_next;
                  low_sum     <= ls_next;
                  trans_count <= cnt_next;
                  if (report_hit) begin
                    // Start dividing the high sum
                    div_quo <= hs_next;
                    div_rem <= '0;
                    div_cnt <= '0;
                    state   <= S_DIV_HI;
                  end
                end else begin
                  high_sum    <= hs_base;
                  low_sum     <= ls_base;
                  trans_count <= cnt_base;
                end
              end
            end
          end
        end
        S_DIV_HI: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == LAST_STEP) begin
            avg_high <= div_quo_next;
            div_quo  <= low_sum;
            div_rem  <= '0;
            div_cnt  <= '0;
            state    <= S_DIV_LO;
          end else begin
            div_quo <= div_quo_next;
            div_rem <= div_rem_next;
          end
        end
        S_DIV_LO: begin
          div_cnt <= div_cnt + 1'b1;
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          if (div_cnt == LAST_STEP) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          advice.valid          <= 1'b1;
          advice.result_kind    <= dbda_pkg::KIND_REPORT;
          advice.verdict        <= report_verdict;
          advice.avg_high_ticks <= avg_high;
          advice.avg_low_ticks  <= div_quo;
          advice.avg_difference <= diff;
          // Drop the window sums once the report is out
          high_sum    <= '0;
          low_sum     <= '0;
          trans_count <= '0;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
